### src/acia_serial_interface_assert.svh
// assertion macros for the serial interface adapter
// expects clk_i and rst_ni in the scope of the including module
`ifndef ACIA_SERIAL_INTERFACE_ASSERT_SVH
`define ACIA_SERIAL_INTERFACE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ACIA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("acia: same-cycle check failed");

// next-cycle implication, disabled during reset
`define ACIA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("acia: next-cycle check failed");

`endif

### src/acia_pkg.sv
// types, status masks and shared constants for the serial interface adapter
// no dependencies
package acia_pkg;

  typedef enum logic [2:0] {
    CMD_READ    = 3'd0,
    CMD_WRITE   = 3'd1,
    CMD_RX_BIT  = 3'd2,
    CMD_RX_BYTE = 3'd3,
    CMD_SET_DCD = 3'd4,
    CMD_SET_CTS = 3'd5,
    CMD_TX_TAKE = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_DATA   = 2'd1,
    PH_PARITY = 2'd2,
    PH_STOP   = 2'd3
  } rx_phase_e;

  localparam logic [7:0] ST_RDRF = 8'h01;
  localparam logic [7:0] ST_TDRE = 8'h02;
  localparam logic [7:0] ST_DCD  = 8'h04;
  localparam logic [7:0] ST_CTS  = 8'h08;
  localparam logic [7:0] ST_FE   = 8'h10;
  localparam logic [7:0] ST_OVRN = 8'h20;
  localparam logic [7:0] ST_PE   = 8'h40;
  localparam logic [7:0] ST_IRQ  = 8'h80;

  localparam logic [1:0] CR_MASTER_RESET = 2'b11;
  localparam logic [1:0] CR_DIV64        = 2'b10;
  localparam logic [1:0] CR_TX_RTS_TIE   = 2'b01;
  localparam logic [1:0] CR_TX_RTS_HIGH  = 2'b10;

  localparam logic [3:0] RX_LEN7   = 4'd7;
  localparam logic [3:0] RX_LEN8   = 4'd8;
  localparam logic [3:0] RX_CNT_MAX = 4'd15;

  typedef struct packed {
    logic [2:0] command;
    logic       reg_select;
    logic [7:0] write_data;
    logic       line_bit;
    logic [7:0] rx_byte;
  } cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic       rts;
    logic       tx_pending;
    logic       byte_accepted;
    logic       tx_notify;
  } rsp_t;

  typedef struct packed {
    rx_phase_e  phase;
    logic [7:0] shift;
    logic [3:0] count;
    logic       parity;
    logic [1:0] div;
    logic       pe;
  } rx_state_t;

  typedef struct packed {
    logic       done;
    logic [7:0] data;
    logic       pe;
    logic       fe;
  } rx_frame_t;

  localparam rx_state_t RX_RESET = '{
    phase:  PH_START,
    shift:  8'h00,
    count:  4'd0,
    parity: 1'b0,
    div:    2'd0,
    pe:     1'b0
  };

endpackage

### src/acia_if.sv
// valid/ready channel interfaces for adapter events and results
// no dependencies
interface acia_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic       reg_select;
  logic [7:0] write_data;
  logic       line_bit;
  logic [7:0] rx_byte;

  modport source (output valid, command, reg_select, write_data, line_bit, rx_byte,
                  input ready);
  modport sink   (input valid, command, reg_select, write_data, line_bit, rx_byte,
                  output ready);
endinterface

interface acia_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       irq;
  logic       rts;
  logic       tx_pending;
  logic       byte_accepted;
  logic       tx_notify;

  modport source (output valid, read_data, irq, rts, tx_pending, byte_accepted, tx_notify,
                  input ready);
  modport sink   (input valid, read_data, irq, rts, tx_pending, byte_accepted, tx_notify,
                  output ready);
endinterface

### src/acia_rx.sv
// bit receiver next-state logic: start, data, parity and stop phases
// depends on acia_pkg
module acia_rx (
  input  acia_pkg::rx_state_t cur_i,
  input  logic [4:0]          ctrl_i,
  input  logic                line_bit_i,
  output acia_pkg::rx_state_t nxt_o,
  output acia_pkg::rx_frame_t frame_o
);
  import acia_pkg::*;

  logic [1:0] div_n;
  logic [3:0] data_len;
  logic [3:0] count_n;
  logic       parity_n;

  assign div_n    = cur_i.div + 2'd1;
  assign data_len = ctrl_i[4] ? RX_LEN8 : RX_LEN7;
  assign count_n  = (cur_i.count != RX_CNT_MAX) ? cur_i.count + 4'd1 : cur_i.count;
  assign parity_n = cur_i.parity ^ line_bit_i;

  always_comb begin
    nxt_o         = cur_i;
    nxt_o.div     = div_n;
    frame_o.done  = 1'b0;
    frame_o.data  = cur_i.shift;
    frame_o.pe    = cur_i.pe;
    frame_o.fe    = ~line_bit_i;
    // divide-by-64 acts on every fourth line bit only
    if (!(ctrl_i[1:0] == CR_DIV64 && div_n != 2'd0)) begin
      unique case (cur_i.phase)
        PH_START: begin
          if (!line_bit_i) nxt_o.phase = PH_DATA;
        end
        PH_DATA: begin
          if (line_bit_i && !cur_i.count[3]) nxt_o.shift[cur_i.count[2:0]] = 1'b1;
          nxt_o.parity = parity_n;
          nxt_o.count  = count_n;
          if (count_n >= data_len) begin
            nxt_o.phase = (ctrl_i[4] && !ctrl_i[3]) ? PH_STOP : PH_PARITY;
          end
        end
        PH_PARITY: begin
          nxt_o.parity = parity_n;
          if (parity_n != ctrl_i[2]) nxt_o.pe = 1'b1;
          nxt_o.phase = PH_STOP;
        end
        PH_STOP: begin
          frame_o.done = 1'b1;
          nxt_o        = RX_RESET;
        end
        default: nxt_o = cur_i;
      endcase
    end
  end

endmodule

### src/acia_regs.sv
// adapter register file: status, control, data registers and event decode
// depends on acia_pkg and acia_rx
module acia_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  acia_pkg::cmd_t cmd_i,
  output acia_pkg::rsp_t rsp_o
);
  import acia_pkg::*;

  logic [7:0] status_q, status_d;
  logic [7:0] control_q, control_d;
  logic [7:0] rdata_q, rdata_d;
  logic [7:0] tdata_q, tdata_d;
  rx_state_t  rx_q, rx_d;
  logic       ovrn_pend_q, ovrn_pend_d;
  logic       carrier_q, carrier_d;

  rx_state_t  rx_nxt;
  rx_frame_t  frame;
  logic [7:0] st;

  function automatic logic [7:0] refresh_f(logic [7:0] s, logic [7:0] c);
    logic fire;
    fire = 1'b0;
    if (c[6:5] == CR_TX_RTS_TIE) fire = ((s & ST_TDRE) != 8'h00) && ((s & ST_CTS) == 8'h00);
    if (c[7]) fire = fire || ((s & (ST_RDRF | ST_DCD | ST_OVRN)) != 8'h00);
    return (s & ~ST_IRQ) | (fire ? ST_IRQ : 8'h00);
  endfunction

  function automatic logic [7:0] view_f(logic [7:0] s, logic carrier);
    logic [7:0] v;
    v = s;
    if ((s & ST_CTS) != 8'h00) v = v & ~ST_TDRE;
    if (carrier) v = v | ST_DCD;
    return v;
  endfunction

  acia_rx u_rx (
    .cur_i      (rx_q),
    .ctrl_i     (control_q[4:0]),
    .line_bit_i (cmd_i.line_bit),
    .nxt_o      (rx_nxt),
    .frame_o    (frame)
  );

  always_comb begin
    st          = status_q;
    control_d   = control_q;
    rdata_d     = rdata_q;
    tdata_d     = tdata_q;
    rx_d        = rx_q;
    ovrn_pend_d = ovrn_pend_q;
    carrier_d   = carrier_q;
    rsp_o       = '0;
    unique case (cmd_e'(cmd_i.command))
      CMD_READ: begin
        if (!cmd_i.reg_select) begin
          rsp_o.read_data = view_f(status_q, carrier_q);
        end else begin
          st = st & ~(ST_DCD | ST_OVRN);
          // deferred overrun shows up on this read, byte stays full
          if (ovrn_pend_q) begin
            ovrn_pend_d = 1'b0;
            st          = st | ST_OVRN;
          end else begin
            st = st & ~ST_RDRF;
          end
          rsp_o.read_data = rdata_q;
        end
      end
      CMD_WRITE: begin
        if (!cmd_i.reg_select) begin
          if (cmd_i.write_data[1:0] == CR_MASTER_RESET) begin
            rdata_d     = 8'h00;
            tdata_d     = 8'h00;
            rx_d        = RX_RESET;
            ovrn_pend_d = 1'b0;
            st          = ST_TDRE | (status_q & ST_CTS);
            control_d   = 8'h00;
          end else begin
            control_d = cmd_i.write_data;
          end
        end else begin
          tdata_d         = cmd_i.write_data;
          st              = st & ~ST_TDRE;
          rsp_o.tx_notify = 1'b1;
        end
      end
      CMD_RX_BIT: begin
        rx_d = rx_nxt;
        if (frame.done) begin
          if ((status_q & ST_RDRF) != 8'h00) begin
            ovrn_pend_d = 1'b1;
          end else begin
            st = (st | ST_RDRF) & ~(ST_FE | ST_PE);
            if (frame.pe) st = st | ST_PE;
            if (frame.fe) st = st | ST_FE;
            rdata_d = frame.data;
          end
        end
      end
      CMD_RX_BYTE: begin
        if ((status_q & ST_RDRF) == 8'h00) begin
          st                  = (st | ST_RDRF) & ~(ST_FE | ST_PE);
          rdata_d             = cmd_i.rx_byte;
          rsp_o.byte_accepted = 1'b1;
        end
      end
      CMD_SET_DCD: begin
        if (cmd_i.line_bit && !carrier_q) st = st | ST_DCD;
        carrier_d = cmd_i.line_bit;
      end
      CMD_SET_CTS: begin
        st = (st & ~ST_CTS) | (cmd_i.line_bit ? ST_CTS : 8'h00);
      end
      CMD_TX_TAKE: begin
        st              = st | ST_TDRE;
        rsp_o.read_data = tdata_q;
      end
      default: st = status_q;
    endcase
    status_d         = refresh_f(st, control_d);
    rsp_o.irq        = (status_d & ST_IRQ) != 8'h00;
    rsp_o.rts        = !((control_d[6:5] == CR_TX_RTS_HIGH) || ((status_d & ST_RDRF) != 8'h00));
    rsp_o.tx_pending = (status_d & ST_TDRE) == 8'h00;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= ST_TDRE;
      control_q   <= 8'h00;
      rdata_q     <= 8'h00;
      tdata_q     <= 8'h00;
      rx_q        <= RX_RESET;
      ovrn_pend_q <= 1'b0;
      carrier_q   <= 1'b0;
    end else if (fire_i) begin
      status_q    <= status_d;
      control_q   <= control_d;
      rdata_q     <= rdata_d;
      tdata_q     <= tdata_d;
      rx_q        <= rx_d;
      ovrn_pend_q <= ovrn_pend_d;
      carrier_q   <= carrier_d;
    end
  end

endmodule

### src/acia_serial_interface.sv
// Serial interface adapter in the style of a classic ACIA. Each event beat (bus read or
// write, received line bit, received byte, DCD or CTS change, transmitter take) yields
// exactly one result beat. An event is latched into an input register; when the output
// register can advance, it is decoded and applied to the register file and its result
// lands in the output register. Throughput is one event per clock while results are
// taken. The input side keeps taking beats while a result waits; it stalls only when
// the output register is held and the input register is already full.
// depends on acia_pkg, acia_if, acia_regs and acia_serial_interface_assert.svh
module acia_serial_interface (
  input logic       clk_i,
  input logic       rst_ni,
  acia_cmd_if.sink   cmd_i,
  acia_rsp_if.source rsp_o
);
  import acia_pkg::*;

  logic           in_valid_q;
  cmd_t           in_q;
  logic           out_valid_q;
  rsp_t           out_q;
  rsp_t           rsp;
  logic           advance;
  logic           fire;

  assign advance     = !out_valid_q || rsp_o.ready;
  assign fire        = in_valid_q && advance;
  assign cmd_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      in_q <= '{command:    cmd_i.command,
                reg_select: cmd_i.reg_select,
                write_data: cmd_i.write_data,
                line_bit:   cmd_i.line_bit,
                rx_byte:    cmd_i.rx_byte};
    end
  end

  acia_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .cmd_i  (in_q),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= rsp;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.read_data     = out_q.read_data;
  assign rsp_o.irq           = out_q.irq;
  assign rsp_o.rts           = out_q.rts;
  assign rsp_o.tx_pending    = out_q.tx_pending;
  assign rsp_o.byte_accepted = out_q.byte_accepted;
  assign rsp_o.tx_notify     = out_q.tx_notify;

  `include "acia_serial_interface_assert.svh"

  // a data write always leaves a byte pending
  `ACIA_ASSERT_NOW(a_notify_pending, rsp_o.valid && rsp_o.tx_notify, rsp_o.tx_pending)
  // a stored byte fills the receive register, which drops rts
  `ACIA_ASSERT_NOW(a_accept_rts, rsp_o.valid && rsp_o.byte_accepted, !rsp_o.rts)
  // an accepted beat is held in the input register
  `ACIA_ASSERT_NEXT(a_in_latched, cmd_i.valid && cmd_i.ready, in_valid_q)

endmodule

### test/testbench.sv
// self-checking bench for acia_serial_interface: random and directed events against a shadow model
// uses acia_pkg and the channel interfaces in acia_if; needs nothing but the rtl
import acia_pkg::*;

localparam logic [2:0] CMD_UNDEFINED = 3'd7;

// control register bit positions
localparam int CTL_RIE    = 7;
localparam int CTL_WORD8  = 4;
localparam int CTL_PARITY = 3;
localparam int CTL_ODD    = 2;

class acia_shadow;
  logic [7:0] status_bits, control_bits, rx_data, tx_data, rx_shift;
  rx_phase_e  rx_phase;
  logic [3:0] rx_count;
  logic [1:0] div_phase;
  logic       rx_parity, pend_pe, pend_fe, pend_ovr, carrier;
  rsp_t       awaited_rsp[$];
  int         mismatches;

  function new();
    mismatches = 0;
    carrier = 1'b0;
    status_bits = '0;
    master_clear();
  endfunction

  function void refresh();
    logic fire;
    fire = 1'b0;
    if (control_bits[6:5] == CR_TX_RTS_TIE)
      fire = (status_bits & ST_TDRE) != 0 && (status_bits & ST_CTS) == 0;
    if (control_bits[CTL_RIE])
      fire = fire || (status_bits & (ST_RDRF | ST_DCD | ST_OVRN)) != 0;
    status_bits = fire ? (status_bits | ST_IRQ) : (status_bits & ~ST_IRQ);
  endfunction

  function logic [7:0] status_view();
    logic [7:0] v;
    v = status_bits;
    if ((v & ST_CTS) != 0) v = v & ~ST_TDRE;
    if (carrier) v = v | ST_DCD;
    return v;
  endfunction

  function void clear_rx();
    rx_shift = '0;
    rx_count = '0;
    rx_parity = 1'b0;
    div_phase = '0;
    pend_pe = 1'b0;
    pend_fe = 1'b0;
  endfunction

  function void master_clear();
    logic [7:0] cts;
    cts = status_bits & ST_CTS;
    rx_data = '0;
    tx_data = '0;
    rx_phase = PH_START;
    clear_rx();
    pend_ovr = 1'b0;
    status_bits = ST_TDRE | cts;
    control_bits = '0;
    refresh();
  endfunction

  function logic store_byte(logic [7:0] b);
    if ((status_bits & ST_RDRF) != 0) return 1'b0;
    status_bits = (status_bits | ST_RDRF) & ~(ST_FE | ST_PE);
    rx_data = b;
    refresh();
    return 1'b1;
  endfunction

  function void end_frame();
    if (!store_byte(rx_shift)) begin
      pend_ovr = 1'b1;
    end else begin
      if (pend_pe) status_bits = status_bits | ST_PE;
      if (pend_fe) status_bits = status_bits | ST_FE;
    end
    clear_rx();
    refresh();
  endfunction

  function void take_line_bit(logic b);
    logic [3:0] len;
    div_phase = div_phase + 2'd1;
    // divide-by-64 acts on every fourth line bit only
    if (control_bits[1:0] == CR_DIV64 && div_phase != 2'd0) return;
    case (rx_phase)
      PH_START: if (!b) rx_phase = PH_DATA;
      PH_DATA: begin
        if (b) begin
          if (rx_count < RX_LEN8) rx_shift[rx_count[2:0]] = 1'b1;
          rx_parity = ~rx_parity;
        end
        if (rx_count < RX_CNT_MAX) rx_count = rx_count + 4'd1;
        len = control_bits[CTL_WORD8] ? RX_LEN8 : RX_LEN7;
        if (rx_count >= len)
          rx_phase = (len == RX_LEN8 && !control_bits[CTL_PARITY]) ? PH_STOP : PH_PARITY;
      end
      PH_PARITY: begin
        if (b) rx_parity = ~rx_parity;
        if (rx_parity != control_bits[CTL_ODD]) pend_pe = 1'b1;
        rx_phase = PH_STOP;
      end
      default: begin
        if (!b) pend_fe = 1'b1;
        end_frame();
        rx_phase = PH_START;
      end
    endcase
  endfunction

  function rsp_t event_outcome(cmd_t c);
    rsp_t r;
    r = '0;
    case (c.command)
      CMD_READ: begin
        if (!c.reg_select) begin
          r.read_data = status_view();
        end else begin
          status_bits = status_bits & ~(ST_DCD | ST_OVRN);
          // overrun shows only after the data read that follows it
          if (pend_ovr) begin
            pend_ovr = 1'b0;
            status_bits = status_bits | ST_OVRN;
          end else begin
            status_bits = status_bits & ~ST_RDRF;
          end
          refresh();
          r.read_data = rx_data;
        end
      end
      CMD_WRITE: begin
        if (!c.reg_select) begin
          if (c.write_data[1:0] == CR_MASTER_RESET) master_clear();
          else control_bits = c.write_data;
        end else begin
          tx_data = c.write_data;
          status_bits = status_bits & ~ST_TDRE;
          r.tx_notify = 1'b1;
        end
        refresh();
      end
      CMD_RX_BIT: take_line_bit(c.line_bit);
      CMD_RX_BYTE: r.byte_accepted = store_byte(c.rx_byte);
      CMD_SET_DCD: begin
        if (c.line_bit && !carrier) status_bits = status_bits | ST_DCD;
        carrier = c.line_bit;
        refresh();
      end
      CMD_SET_CTS: begin
        status_bits = c.line_bit ? (status_bits | ST_CTS) : (status_bits & ~ST_CTS);
        refresh();
      end
      CMD_TX_TAKE: begin
        status_bits = status_bits | ST_TDRE;
        refresh();
        r.read_data = tx_data;
      end
      default: ;
    endcase
    r.irq = (status_bits & ST_IRQ) != 0;
    r.rts = !(control_bits[6:5] == CR_TX_RTS_HIGH || (status_bits & ST_RDRF) != 0);
    r.tx_pending = (status_bits & ST_TDRE) == 0;
    return r;
  endfunction

  function void note_event(cmd_t c);
    awaited_rsp.push_back(event_outcome(c));
  endfunction

  function void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(rsp_t got);
    rsp_t want;
    if (awaited_rsp.size() == 0) begin
      $display("%0t: result beat with nothing pending, expected none, got %0h", $time, got);
      mismatches++;
      return;
    end
    want = awaited_rsp.pop_front();
    compare_field("read_data", want.read_data, got.read_data);
    compare_field("irq", 8'(want.irq), 8'(got.irq));
    compare_field("rts", 8'(want.rts), 8'(got.rts));
    compare_field("tx_pending", 8'(want.tx_pending), 8'(got.tx_pending));
    compare_field("byte_accepted", 8'(want.byte_accepted), 8'(got.byte_accepted));
    compare_field("tx_notify", 8'(want.tx_notify), 8'(got.tx_notify));
  endfunction

  function int outstanding();
    return awaited_rsp.size();
  endfunction
endclass

module testbench;
  localparam int ITEMS       = 1500;
  localparam int HOLD_CYCLES = 64;

  typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} sink_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  acia_cmd_if cmd_ch();
  acia_rsp_if rsp_ch();

  acia_serial_interface DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_ch),
    .rsp_o (rsp_ch)
  );

  acia_shadow sb;
  logic [7:0] fmt;
  bit         no_gaps, hold_req;
  int         burst_left, sent;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cmd_ch.valid && cmd_ch.ready)
        sb.note_event({cmd_ch.command, cmd_ch.reg_select, cmd_ch.write_data,
                       cmd_ch.line_bit, cmd_ch.rx_byte});
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_result({rsp_ch.read_data, rsp_ch.irq, rsp_ch.rts, rsp_ch.tx_pending,
                         rsp_ch.byte_accepted, rsp_ch.tx_notify});
    end
  end

  function automatic cmd_t mk(logic [2:0] op, logic sel, logic [7:0] wd, logic lb,
                              logic [7:0] rb);
    return {op, sel, wd, lb, rb};
  endfunction

  function automatic cmd_t any_event();
    return mk(3'($urandom), 1'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
  endfunction

  // one beat on the event channel, with bursts and gaps
  task automatic put(cmd_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = no_gaps ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    cmd_ch.valid      <= 1'b1;
    cmd_ch.command    <= c.command;
    cmd_ch.reg_select <= c.reg_select;
    cmd_ch.write_data <= c.write_data;
    cmd_ch.line_bit   <= c.line_bit;
    cmd_ch.rx_byte    <= c.rx_byte;
    do @(posedge clk_i); while (!cmd_ch.ready);
    sent++;
    // keep track of the line format for frame generation
    if (c.command == CMD_WRITE && !c.reg_select)
      fmt = (c.write_data[1:0] == CR_MASTER_RESET) ? 8'h00 : c.write_data;
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  task automatic line_bit(logic b);
    repeat ((fmt[1:0] == CR_DIV64) ? 4 : 1)
      put(mk(CMD_RX_BIT, 1'($urandom), 8'($urandom), b, 8'($urandom)));
  endtask

  task automatic read_reg(logic sel);
    put(mk(CMD_READ, sel, 8'($urandom), 1'($urandom), 8'($urandom)));
  endtask

  task automatic write_reg(logic sel, logic [7:0] d);
    put(mk(CMD_WRITE, sel, d, 1'($urandom), 8'($urandom)));
  endtask

  // start, data, optional parity and stop, mostly well formed
  task automatic send_frame();
    logic [7:0] ctl, data;
    logic       pbit;
    int         i;
    if ($urandom_range(0, 3) == 0) write_reg(1'b0, {6'($urandom), CR_MASTER_RESET});
    ctl = 8'($urandom);
    ctl[1:0] = ($urandom_range(0, 3) == 0) ? CR_DIV64 : {1'b0, 1'($urandom)};
    write_reg(1'b0, ctl);
    data = 8'($urandom);
    repeat ($urandom_range(0, 2)) line_bit(1'b1);
    line_bit(1'b0);
    for (i = 0; i < (fmt[CTL_WORD8] ? 8 : 7); i++) begin
      // word length switched mid-frame
      if (i < 3 && $urandom_range(0, 9) == 0) begin
        ctl = fmt;
        ctl[CTL_WORD8] = ~ctl[CTL_WORD8];
        write_reg(1'b0, ctl);
      end
      line_bit(data[i]);
    end
    if (!(fmt[CTL_WORD8] && !fmt[CTL_PARITY])) begin
      pbit = ^(fmt[CTL_WORD8] ? data : {1'b0, data[6:0]}) ^ fmt[CTL_ODD];
      if ($urandom_range(0, 6) == 0) pbit = ~pbit;
      line_bit(pbit);
    end
    line_bit($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 2) == 0) read_reg(1'b0);
    if ($urandom_range(0, 4) < 3) read_reg(1'b1);
  endtask

  task automatic long_hold();
    no_gaps = 1'b1;
    hold_req = 1'b1;
    repeat (40) put(any_event());
    no_gaps = 1'b0;
  endtask

  // sink side: own ready pattern, plus a long hold on request
  initial begin
    sink_mode_e mode;
    int         left, tick;
    logic       r;
    rsp_ch.ready = 1'b0;
    mode = READY_ALWAYS;
    left = 0;
    tick = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if (left == 0) begin
        mode = sink_mode_e'($urandom_range(0, 3));
        left = $urandom_range(20, 200);
      end
      left--;
      tick++;
      case (mode)
        READY_ALWAYS: r = 1'b1;
        READY_COIN:   r = 1'($urandom);
        READY_SPARSE: r = ($urandom_range(0, 3) == 0);
        default:      r = (tick % 3 != 0);
      endcase
      rsp_ch.ready <= r;
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int k;
    sb = new();
    rst_ni = 1'b0;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = CMD_READ;
    cmd_ch.reg_select = 1'b0;
    cmd_ch.write_data = '0;
    cmd_ch.line_bit = 1'b0;
    cmd_ch.rx_byte = '0;
    fmt = '0;
    burst_left = 0;
    sent = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    read_reg(1'b0);
    put(mk(CMD_TX_TAKE, 1'b0, 8'h00, 1'b0, 8'h00));   // nothing pending
    write_reg(1'b1, 8'hff);
    write_reg(1'b0, 8'ha0);                          // rx irq on, tx irq on
    put(mk(CMD_TX_TAKE, 1'b1, 8'hff, 1'b1, 8'hff));
    put(mk(CMD_SET_CTS, 1'b0, 8'h00, 1'b1, 8'h00));
    read_reg(1'b0);
    put(mk(CMD_SET_CTS, 1'b1, 8'hff, 1'b0, 8'hff));
    put(mk(CMD_RX_BYTE, 1'b0, 8'h00, 1'b0, 8'h00));
    put(mk(CMD_RX_BYTE, 1'b1, 8'hff, 1'b1, 8'hff));   // dropped, register full
    read_reg(1'b1);
    put(mk(CMD_SET_DCD, 1'b0, 8'h00, 1'b1, 8'h00));
    read_reg(1'b0);
    read_reg(1'b1);
    write_reg(1'b0, 8'h40);                          // rts forced low
    put(mk(CMD_RX_BYTE, 1'b0, 8'h00, 1'b0, 8'h5a));
    write_reg(1'b0, 8'hff);                          // master reset, carrier still up
    read_reg(1'b0);
    put(mk(CMD_SET_DCD, 1'b1, 8'hff, 1'b0, 8'hff));
    put(mk(CMD_UNDEFINED, 1'b1, 8'hff, 1'b1, 8'hff));
    write_reg(1'b0, 8'h1e);                          // div64, 8 bits, parity
    write_reg(1'b0, 8'h03);

    long_hold();
    drain();

    while (sent < ITEMS) begin
      k = $urandom_range(0, 99);
      if (k < 40) begin
        send_frame();
      end else if (k < 52) begin
        put(mk(CMD_RX_BYTE, 1'($urandom), 8'($urandom), 1'($urandom), 8'($urandom)));
        if ($urandom_range(0, 1) == 0) read_reg(1'b1);
      end else if (k < 64) begin
        write_reg(1'b1, 8'($urandom));
        repeat ($urandom_range(0, 2))
          put(mk(CMD_TX_TAKE, 1'($urandom), 8'($urandom), 1'($urandom), 8'($urandom)));
      end else if (k < 72) begin
        write_reg(1'b0, ($urandom_range(0, 15) == 0) ? 8'($urandom) : {6'($urandom), 1'b0,
                  1'($urandom)});
      end else if (k < 82) begin
        put(mk(($urandom_range(0, 1) == 0) ? CMD_SET_DCD : CMD_SET_CTS, 1'($urandom),
               8'($urandom), 1'($urandom), 8'($urandom)));
        read_reg(1'b0);
      end else if (k < 90) begin
        read_reg(1'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) put(any_event());
      end
      if ($urandom_range(0, 19) == 0) no_gaps = ~no_gaps;
      if ($urandom_range(0, 39) == 0) drain();
      if ($urandom_range(0, 59) == 0) long_hold();
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (sb.outstanding() != 0)
        $display("%0t: %0d result beats never arrived", $time, sb.outstanding());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

### sim.f
+incdir+src
src/acia_pkg.sv
src/acia_if.sv
src/acia_rx.sv
src/acia_regs.sv
src/acia_serial_interface.sv
test/testbench.sv
